/* sv/tvbb_pkg.sv */
// Shared types and constants for the transformed vertex bounding box core.
package tvbb_pkg;

  localparam int unsigned QuatWidth = 32;

  typedef enum logic [1:0] {
    CMD_BOX    = 2'd0,
    CMD_POSE   = 2'd1,
    CMD_VERTEX = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_e;

endpackage

/* sv/tvbb_front.sv */
// Front end: command decode and quaternion to rotation matrix conversion.
module tvbb_front import tvbb_pkg::*; #(
  parameter int unsigned COORD_WIDTH    = 32,
  parameter int unsigned QUAT_FRAC_BITS = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cmd_e                          cmd_i,
  input  logic signed [COORD_WIDTH-1:0] v_i [3],
  input  logic signed [COORD_WIDTH-1:0] t_i [3],
  input  logic signed [QuatWidth-1:0]   q_i [4],
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cmd_e                          cmd_o,
  output logic signed [COORD_WIDTH-1:0] v_o [3],
  output logic signed [COORD_WIDTH-1:0] t_o [3],
  output logic signed [QuatWidth-1:0]   q_o [4],
  output logic signed [QUAT_FRAC_BITS+1:0] m_o [9]
);

  localparam int unsigned EW = QUAT_FRAC_BITS + 2;
  localparam int unsigned PW = 2 * QuatWidth;

  logic                          vld_q;
  cmd_e                          cmd_q;
  logic signed [COORD_WIDTH-1:0] v_q [3];
  logic signed [COORD_WIDTH-1:0] t_q [3];
  logic signed [QuatWidth-1:0]   q_q [4];
  logic signed [EW-1:0]          m_q [9];
  logic signed [EW+2:0]          trm [9];
  logic signed [EW+3:0]          e   [9];
  logic signed [EW-1:0]          m_d [9];

  // Rounded 2ab term; magnitude at most 2^(QUAT_FRAC_BITS+3) for Q1.30 inputs.
  function automatic logic signed [EW+2:0] term(input logic signed [QuatWidth-1:0] a,
                                                 input logic signed [QuatWidth-1:0] b);
    logic signed [PW-1:0] p;
    logic        [PW-1:0] mag;
    logic        [PW-1:0] r;
    p   = PW'(a) * PW'(b);
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    r   = (mag + (PW'(1) << (QUAT_FRAC_BITS - 2))) >> (QUAT_FRAC_BITS - 1);
    return p[PW-1] ? -$signed((EW+3)'(r)) : $signed((EW+3)'(r));
  endfunction

  assign trm[0] = term(q_i[1], q_i[1]);
  assign trm[1] = term(q_i[2], q_i[2]);
  assign trm[2] = term(q_i[3], q_i[3]);
  assign trm[3] = term(q_i[1], q_i[2]);
  assign trm[4] = term(q_i[1], q_i[3]);
  assign trm[5] = term(q_i[2], q_i[3]);
  assign trm[6] = term(q_i[0], q_i[1]);
  assign trm[7] = term(q_i[0], q_i[2]);
  assign trm[8] = term(q_i[0], q_i[3]);

  localparam logic signed [EW+2:0] One  = (EW+3)'(1) <<< QUAT_FRAC_BITS;
  localparam logic signed [EW+2:0] EMax = ((EW+3)'(1) <<< (EW - 1)) - (EW+3)'(1);

  always_comb begin
    e[0] = One - (trm[1] + trm[2]);
    e[1] = trm[3] - trm[8];
    e[2] = trm[4] + trm[7];
    e[3] = trm[3] + trm[8];
    e[4] = One - (trm[0] + trm[2]);
    e[5] = trm[5] - trm[6];
    e[6] = trm[4] - trm[7];
    e[7] = trm[5] + trm[6];
    e[8] = One - (trm[0] + trm[1]);
    for (int i = 0; i < 9; i++) begin
      if (e[i] > EMax) m_d[i] = EMax[EW-1:0];
      else if (e[i] < -EMax - 1) m_d[i] = -EMax[EW-1:0] - EW'(1);
      else m_d[i] = e[i][EW-1:0];
    end
  end

  assign in_ready_o = !vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q <= cmd_i;
      v_q   <= v_i;
      t_q   <= t_i;
      q_q   <= q_i;
      m_q   <= m_d;
    end
  end

  assign out_valid_o = vld_q;
  assign cmd_o = cmd_q;
  assign v_o = v_q;
  assign t_o = t_q;
  assign q_o = q_q;
  assign m_o = m_q;

endmodule

/* sv/tvbb_back.sv */
// Back end: vertex transform, corner tracking and result formation.
module tvbb_back import tvbb_pkg::*; #(
  parameter int unsigned COORD_WIDTH    = 32,
  parameter int unsigned QUAT_FRAC_BITS = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cmd_e                          cmd_i,
  input  logic signed [COORD_WIDTH-1:0] v_i [3],
  input  logic signed [COORD_WIDTH-1:0] t_i [3],
  input  logic signed [QuatWidth-1:0]   q_i [4],
  input  logic signed [QUAT_FRAC_BITS+1:0] m_i [9],
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic                          found_o,
  output logic [COORD_WIDTH-1:0]        size_o [3],
  output logic [COORD_WIDTH-1:0]        center_o [3],
  output logic [QuatWidth-1:0]          rot_o [4]
);

  localparam int unsigned EW = QUAT_FRAC_BITS + 2;
  localparam int unsigned PW = EW + COORD_WIDTH;
  localparam int unsigned AW = COORD_WIDTH + 3;
  localparam logic signed [COORD_WIDTH-1:0] CMax = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] CMin = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [QuatWidth-1:0] QOne = QuatWidth'(64'd1 << QUAT_FRAC_BITS);
  localparam logic signed [EW-1:0] MOne = EW'(64'd1 << QUAT_FRAC_BITS);

  // Stage 1: products. Stage 2: sum, saturation and corner update.
  logic                          p_vld_q;
  cmd_e                          p_cmd_q;
  logic signed [COORD_WIDTH-1:0] p_v_q [3];
  logic signed [COORD_WIDTH-1:0] p_t_q [3];
  logic signed [QuatWidth-1:0]   p_q_q [4];
  logic signed [COORD_WIDTH+1:0] prod_q [9];
  logic signed [EW-1:0]          rot_q [9];
  logic signed [COORD_WIDTH-1:0] shift_q [3];
  logic signed [COORD_WIDTH-1:0] lo_q [3], hi_q [3];
  logic                          held_q, anyv_q;
  logic [COORD_WIDTH-1:0]        bsize_q [3];
  logic [COORD_WIDTH-1:0]        bplace_q [3];
  logic [QuatWidth-1:0]          bturn_q [4];
  logic                          r_vld_q, r_found_q;
  logic [COORD_WIDTH-1:0]        r_size_q [3], r_center_q [3];
  logic [QuatWidth-1:0]          r_rot_q [4];

  logic signed [COORD_WIDTH+1:0] prod_d [9];
  logic signed [AW-1:0]          acc [3];
  logic signed [COORD_WIDTH-1:0] vtx [3];
  logic                          stall, p_go, take;
  logic                          ext_ok;
  logic signed [COORD_WIDTH:0]   ext [3], sum [3];

  function automatic logic signed [COORD_WIDTH+1:0] mulr(input logic signed [EW-1:0] a,
      input logic signed [COORD_WIDTH-1:0] b);
    logic signed [PW-1:0] p;
    logic        [PW-1:0] mag, r;
    p   = PW'(a) * PW'(b);
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    r   = (mag + (PW'(1) << (QUAT_FRAC_BITS - 1))) >> QUAT_FRAC_BITS;
    return p[PW-1] ? -$signed((COORD_WIDTH+2)'(r)) : $signed((COORD_WIDTH+2)'(r));
  endfunction

  always_comb begin
    for (int i = 0; i < 9; i++) prod_d[i] = mulr(rot_q[i], v_i[i % 3]);
  end

  // Finish results leave through the result register; stall only there.
  assign stall = p_vld_q && (p_cmd_q == CMD_FINISH) && r_vld_q && !res_ready_i;
  assign p_go  = p_vld_q && !stall;
  assign in_ready_o = !stall;
  assign take  = in_valid_i && in_ready_o;

  always_comb begin
    ext_ok = anyv_q;
    for (int i = 0; i < 3; i++) begin
      acc[i] = AW'(shift_q[i]) + AW'(prod_q[3*i]) + AW'(prod_q[3*i+1]) + AW'(prod_q[3*i+2]);
      if (acc[i] > AW'(CMax)) vtx[i] = CMax;
      else if (acc[i] < AW'(CMin)) vtx[i] = CMin;
      else vtx[i] = acc[i][COORD_WIDTH-1:0];
      ext[i] = (COORD_WIDTH+1)'(hi_q[i]) - (COORD_WIDTH+1)'(lo_q[i]);
      sum[i] = (COORD_WIDTH+1)'(hi_q[i]) + (COORD_WIDTH+1)'(lo_q[i]);
      if (ext[i] <= 0) ext_ok = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      r_vld_q <= 1'b0;
      held_q  <= 1'b0;
      anyv_q  <= 1'b0;
      for (int i = 0; i < 9; i++) rot_q[i] <= (i % 4 == 0) ? MOne : '0;
      for (int i = 0; i < 3; i++) begin
        shift_q[i] <= '0;
        lo_q[i]    <= CMax;
        hi_q[i]    <= CMin;
      end
    end else begin
      if (res_ready_i) r_vld_q <= 1'b0;
      if (!stall) p_vld_q <= take;
      // A pose, and the return to identity at finish, take effect at
      // acceptance, so the products of the next vertex already use them.
      if (take && cmd_i == CMD_POSE) begin
        rot_q   <= m_i;
        shift_q <= t_i;
      end else if (take && cmd_i == CMD_FINISH) begin
        for (int i = 0; i < 9; i++) rot_q[i] <= (i % 4 == 0) ? MOne : '0;
        for (int i = 0; i < 3; i++) shift_q[i] <= '0;
      end
      if (p_go) begin
        unique case (p_cmd_q)
          CMD_BOX: begin
            if (!held_q && p_v_q[0] > 0 && p_v_q[1] > 0 && p_v_q[2] > 0) held_q <= 1'b1;
          end
          CMD_VERTEX: begin
            anyv_q <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              if (vtx[i] < lo_q[i]) lo_q[i] <= vtx[i];
              if (vtx[i] > hi_q[i]) hi_q[i] <= vtx[i];
            end
          end
          CMD_FINISH: begin
            r_vld_q <= 1'b1;
            held_q  <= 1'b0;
            anyv_q  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              lo_q[i] <= CMax;
              hi_q[i] <= CMin;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      p_cmd_q <= cmd_i;
      p_v_q   <= v_i;
      p_t_q   <= t_i;
      p_q_q   <= q_i;
      prod_q  <= prod_d;
    end
    if (p_go && p_cmd_q == CMD_BOX && !held_q) begin
      for (int i = 0; i < 3; i++) begin
        bsize_q[i]  <= p_v_q[i];
        bplace_q[i] <= p_t_q[i];
      end
      for (int i = 0; i < 4; i++) bturn_q[i] <= p_q_q[i];
    end
    if (p_go && p_cmd_q == CMD_FINISH) begin
      r_found_q <= held_q || ext_ok;
      if (held_q) begin
        r_size_q   <= bsize_q;
        r_center_q <= bplace_q;
        r_rot_q    <= bturn_q;
      end else if (ext_ok) begin
        for (int i = 0; i < 3; i++) begin
          r_size_q[i]   <= ext[i][COORD_WIDTH-1:0];
          r_center_q[i] <= sum[i][COORD_WIDTH:1];
        end
        r_rot_q[0] <= QOne;
        for (int i = 1; i < 4; i++) r_rot_q[i] <= '0;
      end else begin
        for (int i = 0; i < 4; i++) r_rot_q[i] <= '0;
        for (int i = 0; i < 3; i++) begin
          r_size_q[i]   <= '0;
          r_center_q[i] <= '0;
        end
      end
    end
  end

  assign res_valid_o = r_vld_q;
  assign found_o  = r_found_q;
  assign size_o   = r_size_q;
  assign center_o = r_center_q;
  assign rot_o    = r_rot_q;

endmodule

/* sv/transformed_vertex_bounding_box_core.sv */
// Top level of the transformed vertex bounding box core.
// Usage: commands enter on the slave stream s_axis_*. Each transaction
// carries a two-bit command in tuser and the coordinate, translation and
// quaternion fields in tdata. Box, pose and vertex commands give no
// output; a finish command gives exactly one transaction on m_axis_*,
// carrying found in tuser and the box extent, centre and orientation
// in tdata.
// The front stage turns the pose quaternion into a rotation matrix as
// the command is registered. The nine products are formed as the command
// passes into the back stage, and the sums, saturation and corner update
// follow in the next cycle. A finish result is therefore presented from
// the result register, behind the front and product registers.
// The core takes one command per cycle unless a finish command waits
// for an earlier result that is still not taken.
// Reset clears the held box, the pose and the corner registers.
// When the receiver stalls, vertices keep flowing. A finish command
// waits only while an earlier result is still not taken. The front
// register then fills, and s_axis_tready falls.
module transformed_vertex_bounding_box_core import tvbb_pkg::*; #(
  parameter int unsigned COORD_WIDTH    = 32,
  parameter int unsigned QUAT_FRAC_BITS = 30
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: x, y, z, tx, ty, tz (COORD_WIDTH each), qw, qx, qy, qz (32 each).
  input  logic [6*COORD_WIDTH+4*QuatWidth-1:0] s_axis_tdata,
  // tuser: cmd.
  input  logic [1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: size_x, size_y, size_z, center_x, center_y, center_z, rot_w..rot_z.
  output logic [6*COORD_WIDTH+4*QuatWidth-1:0] m_axis_tdata,
  // tuser: found.
  output logic m_axis_tuser
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned EW = QUAT_FRAC_BITS + 2;

  logic signed [CW-1:0] v_in [3], t_in [3], v_f [3], t_f [3];
  logic signed [QuatWidth-1:0] q_in [4], q_f [4];
  logic signed [EW-1:0] m_f [9];
  logic [CW-1:0] size_r [3], center_r [3];
  logic [QuatWidth-1:0] rot_r [4];
  cmd_e cmd_f;
  logic f_vld, f_rdy;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_in[i] = s_axis_tdata[i*CW +: CW];
      t_in[i] = s_axis_tdata[(3+i)*CW +: CW];
      m_axis_tdata[i*CW +: CW]     = size_r[i];
      m_axis_tdata[(3+i)*CW +: CW] = center_r[i];
    end
    for (int i = 0; i < 4; i++) begin
      q_in[i] = s_axis_tdata[6*CW + i*QuatWidth +: QuatWidth];
      m_axis_tdata[6*CW + i*QuatWidth +: QuatWidth] = rot_r[i];
    end
  end

  tvbb_front #(.COORD_WIDTH(COORD_WIDTH), .QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cmd_i(cmd_e'(s_axis_tuser)), .v_i(v_in), .t_i(t_in), .q_i(q_in),
    .out_valid_o(f_vld), .out_ready_i(f_rdy),
    .cmd_o(cmd_f), .v_o(v_f), .t_o(t_f), .q_o(q_f), .m_o(m_f)
  );

  tvbb_back #(.COORD_WIDTH(COORD_WIDTH), .QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i(f_vld), .in_ready_o(f_rdy),
    .cmd_i(cmd_f), .v_i(v_f), .t_i(t_f), .q_i(q_f), .m_i(m_f),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .found_o(m_axis_tuser), .size_o(size_r), .center_o(center_r), .rot_o(rot_r)
  );

endmodule

/* sv/tvbb_checker.sv */
// Port-level checker for the bounding box core, with its bind.
module tvbb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
    else $error("result dropped while stalled");

  a_ready_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with no pending result");

  // With the receiver ready, nothing can hold the input back.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while the receiver is ready");

endmodule

bind transformed_vertex_bounding_box_core tvbb_checker u_tvbb_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tuser
);

/* sim/tb_transformed_vertex_bounding_box_core.sv */
// Testbench for the transformed vertex bounding box core: directed and random command streams.
`timescale 1ns / 1ps

module tb_transformed_vertex_bounding_box_core;
  import tvbb_pkg::*;

  localparam int unsigned CW = 32;
  localparam int unsigned QF = 30;
  localparam int unsigned DW = 6 * CW + 4 * QuatWidth;
  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;
  localparam longint QONE = 64'sd1 << QF;
  localparam int IdleLimit = 2000;

  typedef logic [31:0] words_t [10];

  typedef struct {
    bit found;
    logic [DW-1:0] data;
  } box_result_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [DW-1:0] m_axis_tdata;
  logic m_axis_tuser;

  transformed_vertex_bounding_box_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Own copy of the block state.
  bit held_box;
  longint held_size [3];
  longint held_place [3];
  longint held_quat [4];
  longint pose_mat [9];
  longint pose_shift [3];
  longint lo_corner [3];
  longint hi_corner [3];
  bit seen_vertex;

  box_result_t pending_boxes[$];
  int mismatches;
  int idle_cycles;
  bit quiet;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint round_mul(longint a, longint b, int s);
    longint p, m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (p < 0) ? -m : m;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void clear_object();
    held_box = 1'b0;
    seen_vertex = 1'b0;
    for (int i = 0; i < 3; i++) begin
      held_size[i] = 0;
      held_place[i] = 0;
      pose_shift[i] = 0;
      lo_corner[i] = CMAX;
      hi_corner[i] = CMIN;
    end
    held_quat[0] = QONE;
    for (int i = 1; i < 4; i++) held_quat[i] = 0;
    for (int i = 0; i < 9; i++) pose_mat[i] = (i % 4 == 0) ? QONE : 0;
  endfunction

  // Advances the state by one command; a finish queues its result.
  function automatic void predict_box(cmd_e c, words_t f);
    longint v [3];
    longint t [3];
    longint q [4];
    longint e [9];
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz, acc;
    box_result_t r;
    bit ok;
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'($signed(f[i]));
      t[i] = longint'($signed(f[3 + i]));
    end
    for (int i = 0; i < 4; i++) q[i] = longint'($signed(f[6 + i]));
    case (c)
      CMD_BOX: begin
        if (!held_box && v[0] > 0 && v[1] > 0 && v[2] > 0) begin
          held_box = 1'b1;
          for (int i = 0; i < 3; i++) begin
            held_size[i] = v[i];
            held_place[i] = t[i];
          end
          for (int i = 0; i < 4; i++) held_quat[i] = q[i];
        end
      end
      CMD_POSE: begin
        xx = round_mul(q[1], q[1], QF - 1);
        yy = round_mul(q[2], q[2], QF - 1);
        zz = round_mul(q[3], q[3], QF - 1);
        xy = round_mul(q[1], q[2], QF - 1);
        xz = round_mul(q[1], q[3], QF - 1);
        yz = round_mul(q[2], q[3], QF - 1);
        wx = round_mul(q[0], q[1], QF - 1);
        wy = round_mul(q[0], q[2], QF - 1);
        wz = round_mul(q[0], q[3], QF - 1);
        e[0] = QONE - (yy + zz); e[1] = xy - wz;          e[2] = xz + wy;
        e[3] = xy + wz;          e[4] = QONE - (xx + zz); e[5] = yz - wx;
        e[6] = xz - wy;          e[7] = yz + wx;          e[8] = QONE - (xx + yy);
        // Entries saturate to QF+2 signed bits, which is 32 here.
        for (int i = 0; i < 9; i++) pose_mat[i] = clamp(e[i], CMIN, CMAX);
        for (int i = 0; i < 3; i++) pose_shift[i] = t[i];
      end
      CMD_VERTEX: begin
        for (int i = 0; i < 3; i++) begin
          acc = pose_shift[i];
          for (int j = 0; j < 3; j++) acc += round_mul(pose_mat[i * 3 + j], v[j], QF);
          acc = clamp(acc, CMIN, CMAX);
          if (acc < lo_corner[i]) lo_corner[i] = acc;
          if (acc > hi_corner[i]) hi_corner[i] = acc;
        end
        seen_vertex = 1'b1;
      end
      default: begin
        r.found = 1'b0;
        r.data = '0;
        if (held_box) begin
          r.found = 1'b1;
          for (int i = 0; i < 3; i++) begin
            r.data[i * 32 +: 32] = held_size[i][31:0];
            r.data[(3 + i) * 32 +: 32] = held_place[i][31:0];
          end
          for (int i = 0; i < 4; i++) r.data[(6 + i) * 32 +: 32] = held_quat[i][31:0];
        end else if (seen_vertex) begin
          ok = 1'b1;
          for (int i = 0; i < 3; i++) if (hi_corner[i] - lo_corner[i] <= 0) ok = 1'b0;
          if (ok) begin
            r.found = 1'b1;
            for (int i = 0; i < 3; i++) begin
              acc = hi_corner[i] - lo_corner[i];
              r.data[i * 32 +: 32] = acc[31:0];
              // Midpoint rounded towards minus infinity.
              acc = (lo_corner[i] + hi_corner[i]) >>> 1;
              r.data[(3 + i) * 32 +: 32] = acc[31:0];
            end
            r.data[6 * 32 +: 32] = QONE[31:0];
          end
        end
        pending_boxes.push_back(r);
        clear_object();
      end
    endcase
  endfunction

  // Sends one command transaction, with a random gap before it.
  task automatic send_cmd(cmd_e c, words_t f);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    for (int i = 0; i < 10; i++) s_axis_tdata[i * 32 +: 32] = f[i];
    s_axis_tuser = c;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_box(c, f);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_boxes.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom_range(0, 32'h00200000) - 32'h00100000;
    endcase
  endfunction

  function automatic logic [31:0] rand_quat();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 32'h40000000 : 32'hc0000000;
    return $urandom_range(0, 32'h80000000) - 32'h40000000;
  endfunction

  function automatic words_t rand_words();
    words_t f;
    for (int i = 0; i < 6; i++) f[i] = rand_coord();
    for (int i = 6; i < 10; i++) f[i] = rand_quat();
    return f;
  endfunction

  function automatic words_t make_words(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic [31:0] qw, logic [31:0] qx,
                                        logic [31:0] qy, logic [31:0] qz);
    words_t f;
    f[0] = x; f[1] = y; f[2] = z;
    f[3] = $urandom; f[4] = $urandom; f[5] = $urandom;
    f[6] = qw; f[7] = qx; f[8] = qy; f[9] = qz;
    return f;
  endfunction

  // Empty finish, rejected boxes, first box wins, extremes and saturation.
  task automatic test_directed();
    send_cmd(CMD_FINISH, make_words(0, 0, 0, 0, 0, 0, 0));
    send_cmd(CMD_BOX, make_words(0, 5, 5, 1, 2, 3, 4));
    send_cmd(CMD_BOX, make_words(32'hffffffff, 5, 5, 1, 2, 3, 4));
    send_cmd(CMD_BOX, make_words(32'h7fffffff, 1, 32'h7fffffff,
                                 32'hc0000000, 32'h40000000, 0, 32'hffffffff));
    send_cmd(CMD_BOX, make_words(7, 7, 7, 0, 0, 0, 0));
    send_cmd(CMD_VERTEX, make_words(1, 2, 3, 0, 0, 0, 0));
    send_cmd(CMD_FINISH, make_words(0, 0, 0, 0, 0, 0, 0));
    // A single vertex has no extent.
    send_cmd(CMD_VERTEX, make_words(32'h10000, 0, 0, 0, 0, 0, 0));
    send_cmd(CMD_FINISH, make_words(0, 0, 0, 0, 0, 0, 0));
    // Full-scale vertices under the identity pose.
    send_cmd(CMD_VERTEX, make_words(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0));
    send_cmd(CMD_VERTEX, make_words(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0));
    send_cmd(CMD_FINISH, make_words(0, 0, 0, 0, 0, 0, 0));
    // An oversized quaternion drives several matrix entries into saturation.
    send_cmd(CMD_POSE, make_words(0, 0, 0, 32'h40000000, 32'h40000000,
                                  32'h40000000, 32'h40000000));
    send_cmd(CMD_VERTEX, make_words(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0));
    send_cmd(CMD_VERTEX, make_words(32'h80000000, 32'h7fffffff, 32'h12345, 0, 0, 0, 0));
    send_cmd(CMD_FINISH, make_words(0, 0, 0, 0, 0, 0, 0));
    send_cmd(CMD_POSE, make_words(0, 0, 0, 32'hc0000000, 32'hc0000000,
                                  32'hc0000000, 32'hc0000000));
    send_cmd(CMD_VERTEX, make_words(32'h30000, 32'hfffd0000, 5, 0, 0, 0, 0));
    send_cmd(CMD_VERTEX, make_words(32'hfffd0000, 32'h30000, 32'hfffffffb, 0, 0, 0, 0));
    send_cmd(CMD_FINISH, make_words(0, 0, 0, 0, 0, 0, 0));
    wait_drained();
  endtask

  // Mostly well-formed objects with random content, some noise.
  task automatic test_random_objects(int n_items);
    int sent;
    int nv;
    sent = 0;
    while (sent < n_items) begin
      if (sent % 150 < 30) quiet = 1'b1;
      else quiet = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        send_cmd(cmd_e'($urandom_range(0, 3)), rand_words());
        sent++;
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          send_cmd(CMD_BOX, rand_words());
          sent++;
        end
        if ($urandom_range(0, 1)) begin
          send_cmd(CMD_POSE, rand_words());
          sent++;
        end
        nv = $urandom_range(0, 12);
        for (int i = 0; i < nv; i++) begin
          send_cmd(CMD_VERTEX, rand_words());
          sent++;
        end
        send_cmd(CMD_FINISH, rand_words());
        sent++;
      end
    end
    quiet = 1'b0;
  endtask

  // Sender holds off until every result is in, then resumes back to back.
  task automatic test_pause_and_resume();
    send_cmd(CMD_VERTEX, rand_words());
    send_cmd(CMD_VERTEX, rand_words());
    send_cmd(CMD_FINISH, rand_words());
    wait_drained();
    quiet = 1'b1;
    for (int i = 0; i < 6; i++) send_cmd(CMD_FINISH, rand_words());
    quiet = 1'b0;
  endtask

  // Receiver: random stall before each result.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Result checker and watchdog.
  always @(posedge clk_i) begin
    box_result_t exp_r;
    bit bad;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transaction for %0d cycles", IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_boxes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction at %0t", $realtime);
        end else begin
          exp_r = pending_boxes.pop_front();
          bad = (exp_r.found !== m_axis_tuser);
          for (int i = 0; i < 10; i++)
            if (exp_r.data[i * 32 +: 32] !== m_axis_tdata[i * 32 +: 32]) bad = 1'b1;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t: found exp %0b got %0b", $realtime,
                       exp_r.found, m_axis_tuser);
              for (int i = 0; i < 10; i++)
                $display("  field %0d exp %h got %h", i, exp_r.data[i * 32 +: 32],
                         m_axis_tdata[i * 32 +: 32]);
            end
          end
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_BOX;
    clear_object();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_objects(900);
    test_pause_and_resume();
    test_random_objects(980);
    s_axis_tvalid = 1'b0;
    wait_drained();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && pending_boxes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
